### src/mcg_pkg.sv
// Package for the month calendar grid: field widths, calendar constants and helper functions.
package mcg_pkg;

    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned SLOT_IDX_W = 6;
    localparam int unsigned DAY_W      = 9;
    localparam int unsigned LEN_W      = 5;
    localparam int unsigned WD_W       = 3;

    localparam int unsigned GRID_SLOTS  = 42;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [MONTH_W-1:0] MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd12;
    localparam logic [MONTH_W-1:0] REFORM_MONTH = 4'd9;

    localparam logic [YEAR_W-1:0] YEAR_FIRST  = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_LAST   = 14'd9999;
    localparam logic [YEAR_W-1:0] REFORM_YEAR = 14'd1752;
    localparam logic [YEAR_W-1:0] CENT_START  = 14'd1700;
    localparam logic [YEAR_W-1:0] QUAD_START  = 14'd1600;

    // Division by 100 of a value below 10000 as a multiply and shift.
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned PROD_W       = 27;

    localparam int unsigned CENT_BASE = 17;
    localparam int unsigned QUAD_BASE = 4;

    // Day 1 is a Saturday; the eleven skipped days shift the weekday by three.
    localparam int unsigned EPOCH_WD = 5;
    localparam int unsigned SKIP_WD  = 3;

    // The reform month: days 1 and 2 from slot 2, then the day after the gap from slot 4.
    localparam logic [SLOT_IDX_W-1:0] REFORM_POS  = 6'd2;
    localparam logic [SLOT_IDX_W-1:0] REFORM_JUMP = 6'd4;
    localparam logic [SLOT_IDX_W-1:0] REFORM_END  = 6'd20;
    localparam logic [DAY_W-1:0]      REFORM_GAP  = 9'd11;

    typedef struct packed {
        logic                 blank;
        logic                 reform;
        logic [WD_W-1:0]      pos;
        logic [LEN_W-1:0]     len;
        logic [DAY_W-1:0]     day0;
    } t_grid_desc;

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [LEN_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [DAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Remainder by seven through sums of octal digits, since eight is one modulo seven.
    function automatic logic [WD_W-1:0] mod7(input logic [YEAR_W-1:0] v);
        logic [14:0] w;
        logic [5:0]  f1;
        logic [3:0]  f2;
        logic [2:0]  f3;
        w  = {1'b0, v};
        f1 = 6'(w[2:0]) + 6'(w[5:3]) + 6'(w[8:6]) + 6'(w[11:9]) + 6'(w[14:12]);
        f2 = 4'(f1[5:3]) + 4'(f1[2:0]);
        f3 = 3'(f2[3]) + f2[2:0];
        return (f3 == 3'd7) ? 3'd0 : f3;
    endfunction

endpackage

### src/mcg_front.sv
// Front end: accepts a month and year and works out the grid descriptor in its multiply, year and sum states.
module mcg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mcg_pkg::MONTH_W-1:0]   i_month,
    input  logic [mcg_pkg::YEAR_W-1:0]    i_year,
    input  logic                          i_ordinal,
    output logic                          o_push,
    input  logic                          i_push_ready,
    output mcg_pkg::t_grid_desc           o_desc
);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_YEAR, ST_SUM, ST_PUSH} t_state;

    t_state                         r_state;
    logic [mcg_pkg::MONTH_W-1:0]    r_month;
    logic [mcg_pkg::YEAR_W-1:0]     r_year;
    logic [mcg_pkg::PROD_W-1:0]     r_prod;
    logic                           r_leap;
    logic                           r_ok;
    logic                           r_reform;
    logic [11:0]                    r_lcount;
    logic [mcg_pkg::YEAR_W-1:0]     r_sum;
    logic [mcg_pkg::LEN_W-1:0]      r_len;
    logic [mcg_pkg::DAY_W-1:0]      r_day0;

    logic [mcg_pkg::YEAR_W-1:0]     x;
    logic [7:0]                     c;
    logic [mcg_pkg::YEAR_W-1:0]     rem;
    logic                           div4;
    logic                           div100;
    logic                           div400;
    logic [11:0]                    cent;
    logic [11:0]                    quad;
    logic [mcg_pkg::DAY_W-1:0]      ord;
    logic                           after;

    always_comb begin
        x      = r_year - 14'd1;
        c      = r_prod[mcg_pkg::DIV100_SHIFT +: 8];
        rem    = x - 14'(c) * 14'd100;
        div4   = (r_year[1:0] == 2'd0);
        div100 = (rem == 14'd99);
        div400 = div100 && (2'(c + 8'd1) == 2'd0);
        cent   = (x > mcg_pkg::CENT_START) ? 12'(c) - 12'(mcg_pkg::CENT_BASE) : 12'd0;
        quad   = (x > mcg_pkg::QUAD_START) ? 12'(c[7:2]) - 12'(mcg_pkg::QUAD_BASE) : 12'd0;
        ord    = 9'd1 + mcg_pkg::days_before(r_month)
               + ((r_leap && r_month > mcg_pkg::MONTH_FEB) ? 9'd1 : 9'd0);
        after  = (r_year > mcg_pkg::REFORM_YEAR)
               || (r_year == mcg_pkg::REFORM_YEAR && r_month > mcg_pkg::REFORM_MONTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_month <= i_month;
                        r_year  <= i_year;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= mcg_pkg::PROD_W'(x) * mcg_pkg::PROD_W'(mcg_pkg::DIV100_MUL);
                    r_state <= ST_YEAR;
                end
                ST_YEAR: begin
                    r_ok     <= (r_month >= mcg_pkg::MONTH_FIRST)
                             && (r_month <= mcg_pkg::MONTH_LAST)
                             && (r_year >= mcg_pkg::YEAR_FIRST)
                             && (r_year <= mcg_pkg::YEAR_LAST);
                    r_reform <= (r_month == mcg_pkg::REFORM_MONTH)
                             && (r_year == mcg_pkg::REFORM_YEAR);
                    r_leap   <= (r_year <= mcg_pkg::REFORM_YEAR) ? div4
                             : ((div4 && !div100) || div400);
                    r_lcount <= 12'(x[mcg_pkg::YEAR_W-1:2]) - cent + quad;
                    r_state  <= ST_SUM;
                end
                ST_SUM: begin
                    r_len   <= mcg_pkg::month_len(r_month, r_leap);
                    r_day0  <= i_ordinal ? ord : 9'd1;
                    r_sum   <= x + 14'(r_lcount) + 14'(ord) + 14'(mcg_pkg::EPOCH_WD)
                             + (after ? 14'(mcg_pkg::SKIP_WD) : 14'd0);
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_push      = (r_state == ST_PUSH);
    assign o_desc.blank  = !r_ok;
    assign o_desc.reform = r_reform;
    assign o_desc.pos    = mcg_pkg::mod7(r_sum);
    assign o_desc.len    = r_len;
    assign o_desc.day0   = r_day0;

endmodule

### src/mcg_queue.sv
// Short descriptor queue between the front end and the slot generator.
module mcg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_push_ready,
    input  mcg_pkg::t_grid_desc  i_desc,
    output logic                 o_valid,
    input  logic                 i_pop,
    output mcg_pkg::t_grid_desc  o_desc
);

    localparam int unsigned DEPTH = mcg_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mcg_pkg::t_grid_desc  r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_desc       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/mcg_back.sv
// Back end: walks the slots of the grid at the queue head and drives the output register.
module mcg_back #(
    parameter int unsigned GRID_SLOTS = mcg_pkg::GRID_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_desc_valid,
    input  mcg_pkg::t_grid_desc             i_desc,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mcg_pkg::SLOT_IDX_W-1:0]  o_slot_index,
    output logic [mcg_pkg::DAY_W-1:0]       o_slot_day,
    output logic                            o_last
);

    localparam int unsigned SLOT_W = $clog2(GRID_SLOTS);
    localparam int unsigned IW     = mcg_pkg::SLOT_IDX_W;
    localparam int unsigned DW     = mcg_pkg::DAY_W;

    logic [SLOT_W-1:0]  r_slot;
    logic               r_valid;
    logic [IW-1:0]      r_index;
    logic [DW-1:0]      r_day;
    logic               r_last;

    logic               emit;
    logic               last;
    logic [IW-1:0]      k;
    logic [IW-1:0]      off;
    logic [IW-1:0]      off_r;
    logic [DW-1:0]      day;

    always_comb begin
        emit  = i_desc_valid && (!r_valid || i_ready);
        last  = (r_slot == SLOT_W'(GRID_SLOTS - 1));
        k     = IW'(r_slot);
        off   = k - IW'(i_desc.pos);
        off_r = k - mcg_pkg::REFORM_POS;
        day   = '0;
        if (i_desc.blank) begin
            day = '0;
        end else if (i_desc.reform) begin
            if (k >= mcg_pkg::REFORM_POS && k <= mcg_pkg::REFORM_END) begin
                day = i_desc.day0 + DW'(off_r)
                    + ((k >= mcg_pkg::REFORM_JUMP) ? mcg_pkg::REFORM_GAP : '0);
            end
        end else if (k >= IW'(i_desc.pos) && off < IW'(i_desc.len)) begin
            day = i_desc.day0 + DW'(off);
        end
    end

    assign o_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_slot  <= last ? '0 : r_slot + 1'b1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_index <= k;
            r_day   <= day;
            r_last  <= last;
        end
    end

    assign o_valid      = r_valid;
    assign o_slot_index = r_index;
    assign o_slot_day   = r_day;
    assign o_last       = r_last;

endmodule

### src/month_calendar_grid_top.sv
// Top level of the month calendar grid generator.
//
// An item on the slave stream carries a month and a year. For each accepted item the
// master stream delivers the 42 slots of the month grid in slot order, six rows of seven
// with Sunday first; tlast marks slot 41. A slot holds the day of the month, or the day
// of the year when ordinal mode is set through the configuration port, or 0 when blank.
// An invalid month or year gives an all-blank grid.
// The front end takes each item through its multiply, year and sum steps and then pushes
// its descriptor into the queue. The slot generator emits one slot per cycle while the
// receiver keeps tready high, from the single slot counter; the front end and a two-entry
// queue take further items while a grid is being sent.
// When the receiver holds tready low, the output register keeps its slot and the slot
// counter waits; the queue fills and then the slave side stops accepting.
// Reset clears ordinal mode, the front end sequencer, the queue and the slot counter.
module month_calendar_grid_top #(
    parameter int unsigned GRID_SLOTS = mcg_pkg::GRID_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: month (4), year (14), zero fill (6).
    input  logic [mcg_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: slot_index (6), slot_day (9), zero fill (1).
    output logic [mcg_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    logic                                r_ordinal;
    logic                                push;
    logic                                push_ready;
    mcg_pkg::t_grid_desc                 front_desc;
    logic                                head_valid;
    mcg_pkg::t_grid_desc                 head_desc;
    logic                                pop;
    logic [mcg_pkg::SLOT_IDX_W-1:0]      slot_index;
    logic [mcg_pkg::DAY_W-1:0]           slot_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ordinal <= 1'b0;
        end else if (i_cfg_we) begin
            r_ordinal <= i_cfg_wdata;
        end
    end

    mcg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_month      (i_s_axis_tdata[3:0]),
        .i_year       (i_s_axis_tdata[17:4]),
        .i_ordinal    (r_ordinal),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_desc       (front_desc)
    );

    mcg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_desc       (front_desc),
        .o_valid      (head_valid),
        .i_pop        (pop),
        .o_desc       (head_desc)
    );

    mcg_back #(
        .GRID_SLOTS (GRID_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (head_valid),
        .i_desc       (head_desc),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_slot_index (slot_index),
        .o_slot_day   (slot_day),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, slot_day, slot_index};

endmodule
